// File: hdl/assert_macros.svh
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// File: hdl/m68k_ori_pkg.sv
// Package with step codes, request kinds and helpers for the ORI core.
package m68k_ori_pkg;
   typedef logic [4:0] step_type;
   typedef logic [1:0] kind_type;
   localparam step_type ST_OPCODE   = 5'd0;
   localparam step_type ST_IMM      = 5'd1;
   localparam step_type ST_IMM_HI   = 5'd2;
   localparam step_type ST_IMM_LO   = 5'd3;
   localparam step_type ST_DISP     = 5'd4;
   localparam step_type ST_INDEX    = 5'd5;
   localparam step_type ST_ABSW     = 5'd6;
   localparam step_type ST_ABSL_HI  = 5'd7;
   localparam step_type ST_ABSL_LO  = 5'd8;
   localparam step_type ST_READ_HI  = 5'd9;
   localparam step_type ST_READ_LO  = 5'd10;
   localparam step_type ST_WRITE_HI = 5'd11;
   localparam step_type ST_WRITE_LO = 5'd12;
   localparam step_type ST_CCR      = 5'd13;
   localparam step_type ST_HALT     = 5'd14;
   localparam kind_type KIND_FETCH = 2'd0;
   localparam kind_type KIND_READ  = 2'd1;
   localparam kind_type KIND_WRITE = 2'd2;
   localparam kind_type KIND_HALT  = 2'd3;
   localparam logic [15:0] OP_ORI_CCR = 16'h003C;
   localparam logic [2:0] SIZE_BYTE = 3'd1;
   localparam logic [2:0] SIZE_WORD = 3'd2;
   localparam logic [2:0] SIZE_LONG = 3'd4;

   function automatic logic [31:0] sext16(input logic [15:0] v);
      sext16 = {{16{v[15]}}, v};
   endfunction

   function automatic logic [31:0] sext8(input logic [7:0] v);
      sext8 = {{24{v[7]}}, v};
   endfunction
endpackage

// File: hdl/m68k_ori_with_effective_address.sv
// Top level of the ORI core: sequencer, register file and bus request register.
//   channel | ports                         | direction
//   req     | req_valid req_stall req_bus_word | in  (bus word answering the request)
//   rsp     | rsp_valid rsp_stall rsp_*       | out (next bus request)
// Each bus word is handled combinationally when taken; one request comes out per word.
// A new word is taken every cycle while the result register is empty or drains.
// Reset clears all state; the opcode fetch at address 0 is pending but not shown.
// While rsp_stall is high the pending request holds and req_stall is raised.
`include "assert_macros.svh"
module m68k_ori_with_effective_address (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [15:0] req_bus_word,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_request_kind,
   output logic [31:0] rsp_request_address,
   output logic [15:0] rsp_write_word,
   output logic [3:0]  rsp_condition_flags
);
   import m68k_ori_pkg::*;

   logic [31:0] regs_ff [16];
   logic [31:0] regs_in [16];
   logic [31:0] pc_ff, pc_in, imm_ff, imm_in, addr_ff, addr_in, val_ff, val_in;
   logic [3:0]  flags_ff, flags_in;
   step_type    step_ff, step_in;
   logic [15:0] op_ff, op_in;
   logic [2:0]  size_ff, size_in;
   logic        vld_ff;
   logic [1:0]  kind_ff, kind_in;
   logic [31:0] raddr_ff, raddr_in;
   logic [15:0] wdata_ff, wdata_in;
   logic [3:0]  rflags_ff;
   logic        take;

   assign req_stall = vld_ff & rsp_stall;
   assign take = req_valid & ~req_stall;
   assign rsp_valid = vld_ff;
   assign rsp_request_kind = kind_ff;
   assign rsp_request_address = raddr_ff;
   assign rsp_write_word = wdata_ff;
   assign rsp_condition_flags = rflags_ff;

   always_comb begin
      logic [31:0] x, an, stp, res;
      logic [2:0]  r, md;
      logic [1:0]  sz;
      logic        n, z;
      logic        do_or;
      regs_in = regs_ff;
      pc_in = pc_ff; imm_in = imm_ff; addr_in = addr_ff; val_in = val_ff;
      flags_in = flags_ff; step_in = step_ff; op_in = op_ff; size_in = size_ff;
      r = op_ff[2:0]; md = op_ff[5:3];
      x = '0; an = '0; stp = '0; res = '0; n = 1'b0; z = 1'b0; sz = '0; do_or = 1'b0;
      kind_in = KIND_FETCH; raddr_in = '0; wdata_in = '0;
      unique case (step_ff)
         ST_OPCODE: begin
            pc_in = pc_ff + 32'd2;
            op_in = req_bus_word;
            sz = req_bus_word[7:6];
            r = req_bus_word[2:0]; md = req_bus_word[5:3];
            if (req_bus_word == OP_ORI_CCR) step_in = ST_CCR;
            else if (req_bus_word[15:8] != 8'd0 || sz == 2'd3 || md == 3'd1 ||
                     (md == 3'd7 && r > 3'd1)) step_in = ST_HALT;
            else begin
               size_in = (sz == 2'd0) ? SIZE_BYTE : (sz == 2'd1) ? SIZE_WORD : SIZE_LONG;
               step_in = (size_in == SIZE_LONG) ? ST_IMM_HI : ST_IMM;
            end
         end
         ST_IMM, ST_IMM_LO: begin
            pc_in = pc_ff + 32'd2;
            imm_in = (step_ff == ST_IMM) ? {16'd0, req_bus_word}
                                         : {imm_ff[31:16], req_bus_word};
            stp = (size_ff == SIZE_BYTE && r == 3'd7) ? 32'd2 : {29'd0, size_ff};
            an = regs_ff[{1'b1, r}];
            unique case (md)
               3'd0: begin
                  addr_in = '0; val_in = regs_ff[{1'b0, r}]; do_or = 1'b1;
                  step_in = ST_OPCODE;
               end
               3'd2: begin addr_in = an; step_in = ST_READ_HI; end
               3'd3: begin
                  addr_in = an; regs_in[{1'b1, r}] = an + stp; step_in = ST_READ_HI;
               end
               3'd4: begin
                  addr_in = an - stp; regs_in[{1'b1, r}] = an - stp; step_in = ST_READ_HI;
               end
               3'd5: begin addr_in = an; step_in = ST_DISP; end
               3'd6: begin addr_in = an; step_in = ST_INDEX; end
               default: step_in = (r == 3'd0) ? ST_ABSW : ST_ABSL_HI;
            endcase
         end
         ST_IMM_HI: begin
            pc_in = pc_ff + 32'd2; imm_in = {req_bus_word, 16'd0}; step_in = ST_IMM_LO;
         end
         ST_DISP: begin
            pc_in = pc_ff + 32'd2; addr_in = addr_ff + sext16(req_bus_word);
            step_in = ST_READ_HI;
         end
         ST_INDEX: begin
            pc_in = pc_ff + 32'd2;
            x = regs_ff[req_bus_word[15:12]];
            addr_in = addr_ff + sext8(req_bus_word[7:0]) +
                      (req_bus_word[11] ? x : sext16(x[15:0]));
            step_in = ST_READ_HI;
         end
         ST_ABSW: begin
            pc_in = pc_ff + 32'd2; addr_in = sext16(req_bus_word); step_in = ST_READ_HI;
         end
         ST_ABSL_HI: begin
            pc_in = pc_ff + 32'd2; addr_in = {req_bus_word, 16'd0}; step_in = ST_ABSL_LO;
         end
         ST_ABSL_LO: begin
            pc_in = pc_ff + 32'd2; addr_in = {addr_ff[31:16], req_bus_word};
            step_in = ST_READ_HI;
         end
         ST_READ_HI: begin
            if (size_ff == SIZE_LONG) begin
               val_in = {req_bus_word, 16'd0}; step_in = ST_READ_LO;
            end else begin
               val_in = {16'd0, req_bus_word}; do_or = 1'b1; step_in = ST_WRITE_HI;
            end
         end
         ST_READ_LO: begin
            val_in = {val_ff[31:16], req_bus_word}; do_or = 1'b1; step_in = ST_WRITE_HI;
         end
         ST_WRITE_HI: step_in = (size_ff == SIZE_LONG) ? ST_WRITE_LO : ST_OPCODE;
         ST_WRITE_LO: step_in = ST_OPCODE;
         ST_CCR: begin
            pc_in = pc_ff + 32'd2; flags_in = flags_ff | req_bus_word[3:0];
            step_in = ST_OPCODE;
         end
         default: step_in = ST_HALT;
      endcase

      // OR in the immediate and set N and Z; V and C are cleared; a Dn destination is written back.
      if (do_or) begin
         if (size_ff == SIZE_BYTE) begin
            if (md != 3'd0 && !addr_in[0]) begin
               val_in = val_in | {16'd0, imm_in[7:0], 8'd0};
               res = {24'd0, val_in[15:8]};
            end else begin
               val_in = val_in | {24'd0, imm_in[7:0]};
               res = {24'd0, val_in[7:0]};
            end
            n = res[7]; z = (res[7:0] == 8'd0);
         end else if (size_ff == SIZE_WORD) begin
            val_in = val_in | {16'd0, imm_in[15:0]};
            n = val_in[15]; z = (val_in[15:0] == 16'd0);
         end else begin
            val_in = val_in | imm_in;
            n = val_in[31]; z = (val_in == 32'd0);
         end
         flags_in = {n, z, 2'b00};
         if (md == 3'd0) regs_in[{1'b0, r}] = val_in;
      end

      unique case (step_in)
         ST_READ_HI, ST_WRITE_HI: begin
            kind_in = (step_in == ST_READ_HI) ? KIND_READ : KIND_WRITE;
            raddr_in = (size_ff == SIZE_BYTE) ? {addr_in[31:1], 1'b0} : addr_in;
            if (step_in == ST_WRITE_HI)
               wdata_in = (size_ff == SIZE_LONG) ? val_in[31:16] : val_in[15:0];
         end
         ST_READ_LO: begin kind_in = KIND_READ; raddr_in = addr_in + 32'd2; end
         ST_WRITE_LO: begin
            kind_in = KIND_WRITE; raddr_in = addr_in + 32'd2; wdata_in = val_in[15:0];
         end
         ST_HALT: kind_in = KIND_HALT;
         default: begin kind_in = KIND_FETCH; raddr_in = pc_in; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= '0;
         pc_ff <= '0; imm_ff <= '0; addr_ff <= '0; val_ff <= '0;
         flags_ff <= '0; step_ff <= ST_OPCODE; op_ff <= '0; size_ff <= '0;
         vld_ff <= 1'b0; kind_ff <= KIND_FETCH; raddr_ff <= '0;
         wdata_ff <= '0; rflags_ff <= '0;
      end else if (take) begin
         regs_ff <= regs_in;
         pc_ff <= pc_in; imm_ff <= imm_in; addr_ff <= addr_in; val_ff <= val_in;
         flags_ff <= flags_in; step_ff <= step_in; op_ff <= op_in; size_ff <= size_in;
         vld_ff <= 1'b1; kind_ff <= kind_in; raddr_ff <= raddr_in;
         wdata_ff <= wdata_in; rflags_ff <= flags_in;
      end else if (!rsp_stall) begin
         vld_ff <= 1'b0;
      end
   end

   `ASSERT_IMP(a_halt_sticky, clock, reset, step_ff == ST_HALT, kind_ff == KIND_HALT, "halt lost")
   `ASSERT_IMP(a_write_data, clock, reset, kind_ff != KIND_WRITE, wdata_ff == 16'd0, "stray data")
   `ASSERT_NEXT(a_hold_stall, clock, reset, vld_ff && rsp_stall, vld_ff && $stable(raddr_ff), "moved")
endmodule

// File: sim/m68k_ori_with_effective_address_tb.sv
// Testbench for the ORI core: bus-word stimulus, expected bus requests and checking.
`timescale 1ns / 1ps
module m68k_ori_with_effective_address_tb;
   import m68k_ori_pkg::*;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] address;
      logic [15:0] data;
      logic [3:0]  flags;
   } bus_request_type;

   class ori_scoreboard;
      logic [31:0] regs [16];
      logic [31:0] pc, imm, oaddr, oval;
      logic [3:0]  ccr;
      step_type    step;
      logic [15:0] opcode;
      logic [2:0]  osize;
      bus_request_type pending_requests[$];
      int errors, checked;
      int kind_count [4];

      function void clear();
         foreach (regs[i]) regs[i] = '0;
         pc = '0; imm = '0; oaddr = '0; oval = '0; ccr = '0;
         step = ST_OPCODE; opcode = '0; osize = '0;
         errors = 0; checked = 0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      task report(input string what, input logic [31:0] got, input logic [31:0] want);
         errors++;
         $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
      endtask

      function void or_immediate();
         logic [7:0] res;
         logic n, z;
         if (osize == SIZE_BYTE) begin
            if (opcode[5:3] != 3'd0 && !oaddr[0]) begin
               oval = oval | {16'h0, imm[7:0], 8'h00};
               res = oval[15:8];
            end else begin
               oval = oval | {24'h0, imm[7:0]};
               res = oval[7:0];
            end
            n = res[7]; z = (res == 8'h00);
         end else if (osize == SIZE_WORD) begin
            oval = oval | {16'h0, imm[15:0]};
            n = oval[15]; z = (oval[15:0] == 16'h0);
         end else begin
            oval = oval | imm;
            n = oval[31]; z = (oval == 32'h0);
         end
         ccr = {n, z, 2'b00};
      endfunction

      function void begin_operand();
         logic [2:0]  r;
         logic [31:0] inc;
         r = opcode[2:0];
         inc = (osize == SIZE_BYTE && r == 3'd7) ? 32'd2 : {29'd0, osize};
         case (opcode[5:3])
            3'd0: begin
               oaddr = '0;
               oval = regs[r];
               or_immediate();
               regs[r] = oval;
               step = ST_OPCODE;
            end
            3'd2: begin oaddr = regs[8+r]; step = ST_READ_HI; end
            3'd3: begin oaddr = regs[8+r]; regs[8+r] += inc; step = ST_READ_HI; end
            3'd4: begin regs[8+r] -= inc; oaddr = regs[8+r]; step = ST_READ_HI; end
            3'd5: begin oaddr = regs[8+r]; step = ST_DISP; end
            3'd6: begin oaddr = regs[8+r]; step = ST_INDEX; end
            default: step = (r == 3'd0) ? ST_ABSW : ST_ABSL_HI;
         endcase
      endfunction

      function void decode_opcode(input logic [15:0] op);
         logic [1:0] sz;
         opcode = op;
         sz = op[7:6];
         if (op == OP_ORI_CCR) step = ST_CCR;
         else if (op[15:8] != 8'h00) step = ST_HALT;
         else if (sz == 2'd3 || op[5:3] == 3'd1 || (op[5:3] == 3'd7 && op[2:0] > 3'd1))
            step = ST_HALT;
         else begin
            osize = (sz == 2'd0) ? SIZE_BYTE : (sz == 2'd1) ? SIZE_WORD : SIZE_LONG;
            step = (osize == SIZE_LONG) ? ST_IMM_HI : ST_IMM;
         end
      endfunction

      // Advances the core state by one transfer and queues the request it causes.
      function void note_word(input logic [15:0] w);
         logic [31:0] x;
         bus_request_type r;
         case (step)
            ST_OPCODE:  begin pc += 2; decode_opcode(w); end
            ST_IMM:     begin pc += 2; imm = {16'h0, w}; begin_operand(); end
            ST_IMM_HI:  begin pc += 2; imm = {w, 16'h0}; step = ST_IMM_LO; end
            ST_IMM_LO:  begin pc += 2; imm[15:0] = w; begin_operand(); end
            ST_DISP:    begin pc += 2; oaddr += {{16{w[15]}}, w}; step = ST_READ_HI; end
            ST_INDEX: begin
               x = regs[w[15:12]];
               pc += 2;
               oaddr += {{24{w[7]}}, w[7:0]};
               oaddr += w[11] ? x : {{16{x[15]}}, x[15:0]};
               step = ST_READ_HI;
            end
            ST_ABSW:    begin pc += 2; oaddr = {{16{w[15]}}, w}; step = ST_READ_HI; end
            ST_ABSL_HI: begin pc += 2; oaddr = {w, 16'h0}; step = ST_ABSL_LO; end
            ST_ABSL_LO: begin pc += 2; oaddr[15:0] = w; step = ST_READ_HI; end
            ST_READ_HI: begin
               if (osize == SIZE_LONG) begin
                  oval = {w, 16'h0}; step = ST_READ_LO;
               end else begin
                  oval = {16'h0, w}; or_immediate(); step = ST_WRITE_HI;
               end
            end
            ST_READ_LO: begin oval[15:0] = w; or_immediate(); step = ST_WRITE_HI; end
            ST_WRITE_HI: step = (osize == SIZE_LONG) ? ST_WRITE_LO : ST_OPCODE;
            ST_WRITE_LO: step = ST_OPCODE;
            ST_CCR:     begin pc += 2; ccr = ccr | w[3:0]; step = ST_OPCODE; end
            default:    step = ST_HALT;
         endcase
         r.address = '0; r.data = '0;
         case (step)
            ST_READ_HI, ST_WRITE_HI: begin
               r.kind = (step == ST_READ_HI) ? KIND_READ : KIND_WRITE;
               r.address = (osize == SIZE_BYTE) ? {oaddr[31:1], 1'b0} : oaddr;
               if (r.kind == KIND_WRITE)
                  r.data = (osize == SIZE_LONG) ? oval[31:16] : oval[15:0];
            end
            ST_READ_LO:  begin r.kind = KIND_READ; r.address = oaddr + 2; end
            ST_WRITE_LO: begin r.kind = KIND_WRITE; r.address = oaddr + 2; r.data = oval[15:0]; end
            ST_HALT:     r.kind = KIND_HALT;
            default:     begin r.kind = KIND_FETCH; r.address = pc; end
         endcase
         r.flags = ccr;
         pending_requests.push_back(r);
      endfunction

      task check_request(input bus_request_type got);
         bus_request_type want;
         if (pending_requests.size() == 0) begin
            report("unexpected request", {30'h0, got.kind}, 32'h0);
            return;
         end
         want = pending_requests.pop_front();
         checked++;
         kind_count[got.kind]++;
         if (got.kind != want.kind)
            report("kind", {30'h0, got.kind}, {30'h0, want.kind});
         if (got.address != want.address) report("address", got.address, want.address);
         if (got.data != want.data)
            report("write word", {16'h0, got.data}, {16'h0, want.data});
         if (got.flags != want.flags)
            report("flags", {28'h0, got.flags}, {28'h0, want.flags});
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [15:0] req_bus_word = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [1:0]  rsp_request_kind;
   logic [31:0] rsp_request_address;
   logic [15:0] rsp_write_word;
   logic [3:0]  rsp_condition_flags;

   ori_scoreboard sb;
   int send_idle_pct, recv_idle_pct, hold_cycles;
   logic [15:0] directed_ops[$];
   bit extreme_words;

   m68k_ori_with_effective_address dut (.*);

   always #5 clock = ~clock;

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_stall <= 1'b1;
      end else
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
   end

   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_request('{rsp_request_kind, rsp_request_address, rsp_write_word,
                            rsp_condition_flags});

   function automatic logic [15:0] random_ori();
      logic [2:0] mode, r;
      logic [1:0] sz;
      if ($urandom_range(9) == 0) return OP_ORI_CCR;
      sz = 2'($urandom_range(2));
      case ($urandom_range(6))
         0: mode = 3'd0; 1: mode = 3'd2; 2: mode = 3'd3; 3: mode = 3'd4;
         4: mode = 3'd5; 5: mode = 3'd6; default: mode = 3'd7;
      endcase
      r = 3'($urandom);
      if (mode == 3'd7) r = 3'($urandom_range(1));
      return {8'h00, sz, mode, r};
   endfunction

   // Picks a word that keeps the core in well-formed ORI sequences.
   function automatic logic [15:0] next_word();
      if (sb.step == ST_OPCODE) begin
         if (directed_ops.size() > 0) return directed_ops.pop_front();
         return random_ori();
      end
      if (extreme_words) return $urandom_range(1) ? 16'hFFFF : 16'h0000;
      return 16'($urandom);
   endfunction

   task send_word(input logic [15:0] w);
      if ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_bus_word <= w;
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
      @(negedge clock);
   endtask

   task drain();
      req_valid <= 1'b0;
      while (sb.pending_requests.size() > 0) @(negedge clock);
   endtask

   task run_words(input int count);
      repeat (count) send_word(next_word());
   endtask

   initial begin
      #1000000;
      $display("** m68k_ori_with_effective_address: FAILED **");
      $finish;
   end

   initial begin
      sb = new();
      sb.clear();
      send_idle_pct = 0; recv_idle_pct = 0; hold_cycles = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Every size and destination mode, byte on the stack pointer, and CCR.
      directed_ops = '{16'h0000, 16'h0047, 16'h0090, 16'h0010, 16'h001F, 16'h0067,
                       16'h00A1, 16'h0028, 16'h0036, 16'h0078, 16'h00B9, OP_ORI_CCR};
      extreme_words = 1'b1;
      while (directed_ops.size() > 0 || sb.step != ST_OPCODE) send_word(next_word());
      extreme_words = 1'b0;

      send_idle_pct = 15; recv_idle_pct = 47;
      run_words(400);
      // Long receiver hold-off while words keep being offered.
      hold_cycles = 60;
      run_words(50);
      drain();
      repeat (30) @(negedge clock);
      send_idle_pct = 47; recv_idle_pct = 15;
      run_words(400);
      drain();
      send_idle_pct = 0; recv_idle_pct = 0;
      run_words(480);
      while (sb.step != ST_OPCODE) send_word(next_word());

      // A non-ORI opcode halts the core for good.
      send_word(16'hFFFF);
      repeat (6) send_word(16'($urandom));
      req_valid <= 1'b0;
      while (sb.pending_requests.size() > 0) @(negedge clock);
      repeat (10) @(negedge clock);

      $display("checked %0d bus requests: %0d fetches, %0d reads, %0d writes, %0d halted",
               sb.checked, sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
               sb.kind_count[3]);
      $display("covered all ORI sizes and destination modes, ORI to CCR and the halt");
      if (sb.errors == 0)
         $display("** m68k_ori_with_effective_address: PASSED **");
      else
         $display("** m68k_ori_with_effective_address: FAILED **");
      $finish;
   end
endmodule

// File: sim.f
+incdir+hdl
hdl/m68k_ori_pkg.sv
hdl/m68k_ori_with_effective_address.sv
sim/m68k_ori_with_effective_address_tb.sv
